### src/afbe_pkg.sv
`default_nettype none
package afbe_pkg;

	localparam logic [7:0] START_DELIM = 8'h7E;
	localparam logic [7:0] ESC_BYTE    = 8'h7D;
	localparam logic [7:0] XON_BYTE    = 8'h11;
	localparam logic [7:0] XOFF_BYTE   = 8'h13;
	localparam logic [7:0] ESC_XOR     = 8'h20;
	localparam logic [7:0] CSUM_BASE   = 8'hFF;
	localparam logic [8:0] HEADER_LEN  = 9'd14;

	localparam logic [7:0] RST_FRAME_TYPE  = 8'd16;
	localparam logic [7:0] RST_FRAME_IDENT = 8'd150;
	localparam logic [7:0] RST_HOP_RADIUS  = 8'd0;
	localparam logic [7:0] RST_TX_OPTIONS  = 8'd0;

	typedef enum logic [1:0] {
		REG_FRAME_TYPE  = 2'd0,
		REG_FRAME_IDENT = 2'd1,
		REG_HOP_RADIUS  = 2'd2,
		REG_TX_OPTIONS  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_PAYLOAD = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        cmd;
		logic [63:0] dest_long;
		logic [15:0] dest_short;
		logic [7:0]  payload_count;
		logic [7:0]  data_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_last;
	} out_word_t;

	typedef struct packed {
		logic [7:0] frame_type;
		logic [7:0] frame_ident;
		logic [7:0] hop_radius;
		logic [7:0] tx_options;
	} cfg_regs_t;

	// classified item passed from front to back
	typedef struct packed {
		logic        is_start;
		logic        close;
		logic [63:0] dest_long;
		logic [15:0] dest_short;
		logic [7:0]  payload_count;
		logic [7:0]  data_byte;
	} entry_t;

endpackage
`default_nettype wire

### src/afbe_front.sv
`default_nettype none
module afbe_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire afbe_pkg::in_word_t in_data,
	output logic                   push,
	output afbe_pkg::entry_t       push_entry,
	input  wire logic              q_full
);
	import afbe_pkg::*;

	logic       frame_open_q;
	logic [7:0] bytes_left_q;
	logic       accept;
	logic       is_start;
	logic       live_payload;

	assign in_ready     = !q_full;
	assign accept       = in_valid && in_ready;
	assign is_start     = (in_data.cmd == CMD_START);
	assign live_payload = frame_open_q && (bytes_left_q != 8'd0);
	assign push         = accept && (is_start || live_payload);

	always_comb begin
		push_entry.is_start      = is_start;
		push_entry.close         = is_start ? (in_data.payload_count == 8'd0)
		                                    : (bytes_left_q == 8'd1);
		push_entry.dest_long     = in_data.dest_long;
		push_entry.dest_short    = in_data.dest_short;
		push_entry.payload_count = in_data.payload_count;
		push_entry.data_byte     = in_data.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= 8'd0;
		end else if (accept) begin
			if (is_start) begin
				frame_open_q <= (in_data.payload_count != 8'd0);
				bytes_left_q <= in_data.payload_count;
			end else if (live_payload) begin
				bytes_left_q <= bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

### src/afbe_queue.sv
`default_nettype none
module afbe_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire afbe_pkg::entry_t push_entry,
	output logic                  full,
	input  wire logic             pop,
	output logic                  q_valid,
	output afbe_pkg::entry_t      q_entry
);
	import afbe_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### src/afbe_back.sv
`default_nettype none
module afbe_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire afbe_pkg::cfg_regs_t cfg,
	input  wire logic                q_valid,
	input  wire afbe_pkg::entry_t    q_entry,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output afbe_pkg::out_word_t      out_data
);
	import afbe_pkg::*;

	localparam logic [4:0] POS_DELIM    = 5'd0;
	localparam logic [4:0] POS_LEN_HI   = 5'd1;
	localparam logic [4:0] POS_LEN_LO   = 5'd2;
	localparam logic [4:0] POS_TYPE     = 5'd3;
	localparam logic [4:0] POS_IDENT    = 5'd4;
	localparam logic [4:0] POS_LONG0    = 5'd5;
	localparam logic [4:0] POS_LONG7    = 5'd12;
	localparam logic [4:0] POS_SHORT_HI = 5'd13;
	localparam logic [4:0] POS_SHORT_LO = 5'd14;
	localparam logic [4:0] POS_RADIUS   = 5'd15;
	localparam logic [4:0] POS_OPTIONS  = 5'd16;
	localparam logic [4:0] POS_DATA     = 5'd17;
	localparam logic [4:0] POS_CSUM     = 5'd18;

	entry_t     cur_q;
	logic       busy_q;
	logic [4:0] pos_q;
	logic       esc_q;
	logic [7:0] sum_q;
	out_word_t  out_q;
	logic       out_valid_q;

	logic [8:0] len;
	logic [4:0] long_sel;
	logic [7:0] raw;
	logic       need_esc;
	logic       final_byte;
	logic       last_pos;
	logic       is_data;
	logic       adv;
	logic       item_done;
	logic       load;
	logic [4:0] pos_next;
	logic [7:0] sum_next;
	out_word_t  word;

	assign len      = {1'b0, cur_q.payload_count} + HEADER_LEN;
	assign long_sel = POS_LONG7 - pos_q;

	always_comb begin
		case (pos_q) inside
			POS_DELIM:            raw = START_DELIM;
			POS_LEN_HI:           raw = {7'd0, len[8]};
			POS_LEN_LO:           raw = len[7:0];
			POS_TYPE:             raw = cfg.frame_type;
			POS_IDENT:            raw = cfg.frame_ident;
			[POS_LONG0:POS_LONG7]: raw = cur_q.dest_long[{long_sel[2:0], 3'd0} +: 8];
			POS_SHORT_HI:         raw = cur_q.dest_short[15:8];
			POS_SHORT_LO:         raw = cur_q.dest_short[7:0];
			POS_RADIUS:           raw = cfg.hop_radius;
			POS_OPTIONS:          raw = cfg.tx_options;
			POS_DATA:             raw = cur_q.data_byte;
			POS_CSUM:             raw = CSUM_BASE - sum_q;
			default:              raw = 8'd0;
		endcase
	end

	assign need_esc   = (pos_q != POS_DELIM) &&
	                    (raw == START_DELIM || raw == ESC_BYTE ||
	                     raw == XON_BYTE || raw == XOFF_BYTE);
	assign final_byte = !need_esc || esc_q;
	assign last_pos   = (pos_q == POS_CSUM) ||
	                    (((pos_q == POS_OPTIONS) || (pos_q == POS_DATA)) && !cur_q.close);
	assign is_data    = (pos_q >= POS_TYPE) && (pos_q <= POS_DATA);
	assign adv        = busy_q && (!out_valid_q || out_ready);
	assign item_done  = adv && final_byte && last_pos;
	assign load       = q_valid && (!busy_q || item_done);
	assign pop        = load;
	assign pos_next   = ((pos_q == POS_OPTIONS) || (pos_q == POS_DATA)) ? POS_CSUM
	                                                                    : pos_q + 5'd1;

	always_comb begin
		sum_next = sum_q;
		if (adv && final_byte) begin
			if (is_data) begin
				sum_next = sum_q + raw;
			end else if (pos_q == POS_CSUM) begin
				sum_next = 8'd0;
			end
		end
		if (load && q_entry.is_start) begin
			sum_next = 8'd0;
		end
	end

	always_comb begin
		if (need_esc && !esc_q) begin
			word.out_byte = ESC_BYTE;
		end else if (esc_q) begin
			word.out_byte = raw ^ ESC_XOR;
		end else begin
			word.out_byte = raw;
		end
		word.run_last   = final_byte && last_pos;
		word.frame_last = final_byte && (pos_q == POS_CSUM);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_entry;
		end
		if (adv) begin
			out_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= POS_DELIM;
			esc_q       <= 1'b0;
			sum_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			sum_q <= sum_next;
			if (load) begin
				busy_q <= 1'b1;
				pos_q  <= q_entry.is_start ? POS_DELIM : POS_DATA;
				esc_q  <= 1'b0;
			end else if (item_done) begin
				busy_q <= 1'b0;
				esc_q  <= 1'b0;
			end else if (adv) begin
				if (final_byte) begin
					pos_q <= pos_next;
					esc_q <= 1'b0;
				end else begin
					esc_q <= 1'b1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### src/api_frame_builder_escaped.sv
// Transmit-request frame builder with byte escaping.
// in channel (in_valid/in_ready/in_data): cmd 0 opens a frame with the long
// and short destinations and the payload count; cmd 1 carries one payload
// byte. Payload words with no open frame are taken and dropped.
// out channel (out_valid/out_ready/out_data): one serial byte per word,
// escaped, with run_last on the last byte of an input word and frame_last
// on the final checksum byte.
// cfg channel (cfg_valid/cfg_ready/cfg_addr/cfg_data): always ready; writes
// frame type, frame id, radius and options. Write only while idle.
// A front stage tracks the open frame and filters input words into a
// two-entry queue; the back sequencer emits one byte per cycle into an
// output register unless the receiver stalls. An input word passes the
// queue and the sequencer's loaded entry before its first byte is valid;
// the queue takes new words while the sequencer is busy with an earlier one.
// Reset clears the frame state, the queue and the output; config registers
// take their defaults. A stalled receiver holds the output word and, once
// the queue fills, drops in_ready.
`default_nettype none
module api_frame_builder_escaped (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire afbe_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output afbe_pkg::out_word_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire afbe_pkg::cfg_reg_t  cfg_addr,
	input  wire logic [7:0]          cfg_data
);
	import afbe_pkg::*;

	cfg_regs_t cfg_q;
	logic      push;
	entry_t    push_entry;
	logic      q_full;
	logic      pop;
	logic      q_valid;
	entry_t    q_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_type  <= RST_FRAME_TYPE;
			cfg_q.frame_ident <= RST_FRAME_IDENT;
			cfg_q.hop_radius  <= RST_HOP_RADIUS;
			cfg_q.tx_options  <= RST_TX_OPTIONS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_FRAME_TYPE:  cfg_q.frame_type  <= cfg_data;
				REG_FRAME_IDENT: cfg_q.frame_ident <= cfg_data;
				REG_HOP_RADIUS:  cfg_q.hop_radius  <= cfg_data;
				REG_TX_OPTIONS:  cfg_q.tx_options  <= cfg_data;
				default: ;
			endcase
		end
	end

	afbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	afbe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_entry    (q_entry)
	);

	afbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

### src/afbe_checker.sv
`default_nettype none
module afbe_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire afbe_pkg::out_word_t out_data
);
	import afbe_pkg::*;

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_frame_last_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_last |-> out_data.run_last)
		else $error("frame_last without run_last");

	// an input word never ends on an escape marker
	a_no_trailing_esc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.run_last |-> out_data.out_byte != ESC_BYTE)
		else $error("word ends on escape marker");

	a_delim_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_byte == START_DELIM |-> !out_data.run_last)
		else $error("delimiter ends a word");

endmodule

bind api_frame_builder_escaped afbe_checker u_afbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

### tb/api_frame_builder_escaped_tb.sv
module api_frame_builder_escaped_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import afbe_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 12;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_reg_t  cfg_addr = REG_FRAME_TYPE;
	logic [7:0] cfg_data = '0;

	api_frame_builder_escaped dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// frame model state
	cfg_regs_t  model_cfg;
	logic [7:0] model_sum;
	logic [7:0] model_left;
	logic       model_open;

	out_word_t expected_bytes[$];
	out_word_t word_bytes[$];

	int err_cnt = 0;
	int bytes_checked = 0;
	int frames_closed = 0;
	int words_sent = 0;
	int cycles = 0;

	// sender and receiver pacing
	bit          tx_gaps_on = 1'b0;
	int          burst_left = 0;
	int          rx_mode = 0;
	logic [15:0] rx_pat = 16'hFFFF;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_len = 0;
	int          hold_left = 0;

	function automatic void flag(input string msg);
		err_cnt++;
		if (err_cnt <= 10) $display("%s", msg);
	endfunction

	function automatic bit is_special(input logic [7:0] b);
		return b == START_DELIM || b == ESC_BYTE || b == XON_BYTE || b == XOFF_BYTE;
	endfunction

	function automatic void put_raw(input logic [7:0] b, input logic fl);
		out_word_t o;
		o.out_byte = b;
		o.run_last = 1'b0;
		o.frame_last = fl;
		word_bytes.push_back(o);
	endfunction

	function automatic void put_esc(input logic [7:0] b, input logic fl);
		if (is_special(b)) begin
			put_raw(ESC_BYTE, 1'b0);
			put_raw(b ^ ESC_XOR, fl);
		end else begin
			put_raw(b, fl);
		end
	endfunction

	function automatic void put_data(input logic [7:0] b);
		model_sum = model_sum + b;
		put_esc(b, 1'b0);
	endfunction

	function automatic void put_checksum();
		put_esc(CSUM_BASE - model_sum, 1'b1);
		model_open = 1'b0;
		model_left = '0;
		model_sum = '0;
	endfunction

	function automatic void predict_word(input in_word_t w);
		logic [8:0] flen;
		word_bytes.delete();
		if (w.cmd == CMD_START) begin
			model_sum = '0;
			model_left = w.payload_count;
			model_open = 1'b1;
			flen = {1'b0, w.payload_count} + HEADER_LEN;
			put_raw(START_DELIM, 1'b0);
			put_esc({7'd0, flen[8]}, 1'b0);
			put_esc(flen[7:0], 1'b0);
			put_data(model_cfg.frame_type);
			put_data(model_cfg.frame_ident);
			for (int i = 7; i >= 0; i--)
				put_data(w.dest_long[i*8 +: 8]);
			put_data(w.dest_short[15:8]);
			put_data(w.dest_short[7:0]);
			put_data(model_cfg.hop_radius);
			put_data(model_cfg.tx_options);
			if (model_left == 0) put_checksum();
		end else if (model_open && model_left != 0) begin
			put_data(w.data_byte);
			model_left = model_left - 1'b1;
			if (model_left == 0) put_checksum();
		end
		if (word_bytes.size() > 0) begin
			word_bytes[word_bytes.size() - 1].run_last = 1'b1;
			foreach (word_bytes[i]) expected_bytes.push_back(word_bytes[i]);
		end
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 11))
			0: return START_DELIM;
			1: return ESC_BYTE;
			2: return XON_BYTE;
			3: return XOFF_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [63:0] pick_long();
		logic [63:0] v;
		for (int i = 0; i < 8; i++) v[i*8 +: 8] = pick_byte();
		return v;
	endfunction

	function automatic in_word_t start_word(input logic [63:0] dl, input logic [15:0] ds,
			input logic [7:0] cnt);
		in_word_t w;
		w.cmd = CMD_START;
		w.dest_long = dl;
		w.dest_short = ds;
		w.payload_count = cnt;
		w.data_byte = 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic in_word_t payload_word(input logic [7:0] b);
		in_word_t w;
		w.cmd = CMD_PAYLOAD;
		w.dest_long = {$urandom, $urandom};
		w.dest_short = 16'($urandom_range(0, 65535));
		w.payload_count = 8'($urandom_range(0, 255));
		w.data_byte = b;
		return w;
	endfunction

	function automatic logic [7:0] pick_cfg_byte();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return pick_byte();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_word(input in_word_t w);
		int gap;
		if (tx_gaps_on && burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		predict_word(w);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input cfg_regs_t v);
		cfg_reg_t   a;
		logic [7:0] d;
		for (int i = 0; i < 4; i++) begin
			a = cfg_reg_t'(i);
			case (a)
				REG_FRAME_TYPE:  d = v.frame_type;
				REG_FRAME_IDENT: d = v.frame_ident;
				REG_HOP_RADIUS:  d = v.hop_radius;
				default:         d = v.tx_options;
			endcase
			cfg_valid <= 1'b1;
			cfg_addr <= a;
			cfg_data <= d;
			do @(posedge clk); while (!cfg_ready);
			case (a)
				REG_FRAME_TYPE:  model_cfg.frame_type = d;
				REG_FRAME_IDENT: model_cfg.frame_ident = d;
				REG_HOP_RADIUS:  model_cfg.hop_radius = d;
				default:         model_cfg.tx_options = d;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input logic [7:0] cnt, input int n);
		send_word(start_word(pick_long(), {pick_byte(), pick_byte()}, cnt));
		repeat (n) send_word(payload_word(pick_byte()));
	endtask

	// tests

	task automatic test_defaults_and_stray();
		send_word(payload_word(8'hA5));
		send_word(start_word(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 8'd0));
		send_word(payload_word(8'hFF));
		wait_idle();
	endtask

	task automatic test_escapes();
		send_word(start_word(64'h7E7D_1113_00FF_807F, 16'h7E13, 8'd2));
		send_word(payload_word(ESC_BYTE));
		send_word(payload_word(XON_BYTE));
		// length low byte hits each special value; each start after the first aborts the one before
		send_word(start_word(64'h0, 16'h0, 8'h70));
		send_word(start_word(64'h0, 16'hFFFF, 8'h6F));
		send_word(start_word(64'h0, 16'h0, 8'd3));
		send_word(start_word(64'h1111_1111_1313_1313, 16'h7D7D, 8'd5));
		send_word(payload_word(XOFF_BYTE));
		send_word(payload_word(START_DELIM));
		send_word(payload_word(8'h00));
		send_word(payload_word(8'hFF));
		send_word(payload_word(8'h80));
		wait_idle();
	endtask

	task automatic test_length_msb_and_restart();
		send_word(start_word(64'h0123_4567_89AB_CDEF, 16'h8001, 8'd242));
		send_word(payload_word(8'h55));
		send_word(payload_word(8'hAA));
		send_word(start_word(64'hFEDC_BA98_7654_3210, 16'h7FFE, 8'd255));
		send_word(payload_word(8'h01));
		send_word(start_word(64'h8000_0000_0000_0001, 16'h1234, 8'd241));
		wait_idle();
	endtask

	task automatic test_checksum_escape();
		logic [7:0] targets[4];
		targets = '{START_DELIM, ESC_BYTE, XON_BYTE, XOFF_BYTE};
		foreach (targets[i]) begin
			send_word(start_word({$urandom, $urandom}, 16'($urandom_range(0, 65535)), 8'd1));
			// pick the payload so that the checksum lands on a special value
			send_word(payload_word(CSUM_BASE - targets[i] - model_sum));
		end
		wait_idle();
	endtask

	task automatic test_config_settings();
		cfg_regs_t c;
		c = '0;
		set_config(c);
		send_frame(8'd2, 2);
		wait_idle();
		c = '1;
		set_config(c);
		send_frame(8'd1, 1);
		wait_idle();
		c = '{START_DELIM, ESC_BYTE, XON_BYTE, XOFF_BYTE};
		set_config(c);
		send_frame(8'd0, 0);
		wait_idle();
	endtask

	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		rx_mode = 0;
		hold_len = 300;
		hold_req++;
		send_frame(8'd24, 24);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		cfg_regs_t c;
		int counted;
		int cnt;
		int n;
		for (int phase = 0; phase < 4; phase++) begin
			tx_gaps_on = (phase != 0);
			rx_mode = (phase == 0) ? 0 : ((phase == 2) ? 2 : 1);
			rx_pat = 16'($urandom) | 16'h0101;
			if (phase > 0) begin
				c.frame_type = pick_cfg_byte();
				c.frame_ident = pick_cfg_byte();
				c.hop_radius = pick_cfg_byte();
				c.tx_options = pick_cfg_byte();
				set_config(c);
			end
			counted = 0;
			while (counted < 85) begin
				if ($urandom_range(0, 9) == 0) begin
					send_word(payload_word(pick_byte()));
				end else begin
					case ($urandom_range(0, 9))
						0:       cnt = $urandom_range(200, 255);
						1, 2:    cnt = $urandom_range(7, 40);
						default: cnt = $urandom_range(0, 6);
					endcase
					n = cnt;
					if (cnt >= 200) n = $urandom_range(1, 8);
					else if ($urandom_range(0, 9) == 0) n = $urandom_range(0, cnt);
					send_frame(cnt[7:0], n);
					counted += 1 + n;
				end
			end
			wait_idle();
		end
	endtask

	// receiver
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: begin
					out_ready <= rx_pat[0];
					rx_pat = {rx_pat[0], rx_pat[15:1]};
				end
				default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// output check
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			bytes_checked++;
			if (out_data.frame_last) frames_closed++;
			if (expected_bytes.size() == 0) begin
				flag($sformatf("unexpected word: byte %h run_last %b frame_last %b",
					out_data.out_byte, out_data.run_last, out_data.frame_last));
			end else begin
				e = expected_bytes.pop_front();
				if (out_data.out_byte !== e.out_byte || out_data.run_last !== e.run_last ||
						out_data.frame_last !== e.frame_last)
					flag($sformatf("word %0d mismatch: expected %h/%b/%b got %h/%b/%b",
						bytes_checked, e.out_byte, e.run_last, e.frame_last,
						out_data.out_byte, out_data.run_last, out_data.frame_last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				expected_bytes.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		model_cfg = '{RST_FRAME_TYPE, RST_FRAME_IDENT, RST_HOP_RADIUS, RST_TX_OPTIONS};
		model_sum = '0;
		model_left = '0;
		model_open = 1'b0;
		rx_mode = 1;
		rx_pat = 16'b1011_0111_0110_1101;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults_and_stray();
		tx_gaps_on = 1'b1;
		test_escapes();
		test_length_msb_and_restart();
		test_checksum_escape();
		test_config_settings();
		test_backpressure();
		test_random_traffic();

		if (expected_bytes.size() != 0)
			flag($sformatf("%0d expected words never arrived", expected_bytes.size()));
		$display("sent %0d input words, checked %0d output bytes, %0d frames closed",
			words_sent, bytes_checked, frames_closed);
		$display("covered escapes, length high byte, restarts, stray payloads, config extremes");
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
src/afbe_pkg.sv
src/afbe_front.sv
src/afbe_queue.sv
src/afbe_back.sv
src/api_frame_builder_escaped.sv
src/afbe_checker.sv
tb/api_frame_builder_escaped_tb.sv
